// File: src/edcl_pkg.sv
// ----------------------------------------------------------------------------
// Exponential cohesive law package
// Shared types, register codes and fixed-point constants of the damage core.
// ----------------------------------------------------------------------------
package edcl_pkg;

  localparam int unsigned JumpW   = 32;
  localparam int unsigned DamageW = 17;
  localparam int unsigned CfgW    = 31;

  // One in Q0.16 and Q16.16.
  localparam logic [DamageW-1:0] OneQ16 = 17'd65536;

  // log2(e) and ln(2) in Q0.32 (the first needs 33 bits).
  localparam logic [32:0] Log2eQ32 = 33'd6196328018;
  localparam logic [31:0] Ln2Q32   = 32'd2977044472;

  // Arguments of 24.0 and above give exp(-x) = 0.
  localparam logic [20:0] ExpCutoff = 21'd1572864;

  localparam int unsigned TaylorTerms = 13;

  typedef enum logic [1:0] {
    REG_FRACTURE_ENERGY   = 2'd0,
    REG_TANGENTIAL_WEIGHT = 2'd1,
    REG_SOFTENING_LENGTH  = 2'd2,
    REG_IRREVERSIBLE_MODE = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic signed [JumpW-1:0] jump_normal;
    logic signed [JumpW-1:0] jump_tangent_a;
    logic signed [JumpW-1:0] jump_tangent_b;
    logic [DamageW-1:0]      old_damage;
  } in_item_t;

  typedef struct packed {
    logic signed [JumpW-1:0] traction_normal;
    logic signed [JumpW-1:0] traction_tangent_a;
    logic signed [JumpW-1:0] traction_tangent_b;
    logic [DamageW-1:0]      damage_level;
    logic                    saturated;
  } out_item_t;

  typedef struct packed {
    reg_index_t      index;
    logic [CfgW-1:0] wdata;
  } cfg_write_t;

  // floor(2^33 / k) for the Taylor divisors, used as reciprocal multipliers.
  function automatic logic [33:0] taylor_recip(input int unsigned k);
    logic [33:0] r;
    case (k)
      1:       r = 34'd8589934592;
      2:       r = 34'd4294967296;
      3:       r = 34'd2863311530;
      4:       r = 34'd2147483648;
      5:       r = 34'd1717986918;
      6:       r = 34'd1431655765;
      7:       r = 34'd1227133513;
      8:       r = 34'd1073741824;
      9:       r = 34'd954437176;
      10:      r = 34'd858993459;
      11:      r = 34'd780903144;
      12:      r = 34'd715827882;
      13:      r = 34'd660764199;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/edcl_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// One channel with a payload of any packed type.
// ----------------------------------------------------------------------------
interface edcl_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: src/edcl_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, two result bits per register stage.
// ----------------------------------------------------------------------------
module edcl_sqrt #(
  parameter int unsigned RadicandW = 64,
  parameter type side_t = logic
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [RadicandW-1:0]   radicand,
  input  side_t                  in_side,
  output logic                   out_valid,
  output logic [RadicandW/2-1:0] root,
  output side_t                  out_side
);
  localparam int unsigned RootW  = RadicandW / 2;
  localparam int unsigned RemW   = RootW + 1;
  localparam int unsigned Stages = RootW / 2;
  localparam int unsigned WordW  = RemW + RootW + RadicandW;

  // Word layout: remainder, partial root, radicand bits not yet consumed.
  function automatic logic [WordW-1:0] sqrt_step(input logic [WordW-1:0] wd);
    logic [RemW-1:0]      rem;
    logic [RootW-1:0]     rt;
    logic [RadicandW-1:0] w;
    logic [RemW+1:0]      rem2;
    logic [RemW+1:0]      trial;
    logic [RemW+1:0]      diff;
    rem   = wd[WordW-1 -: RemW];
    rt    = wd[RadicandW +: RootW];
    w     = wd[RadicandW-1:0];
    rem2  = {rem, w[RadicandW-1 -: 2]};
    trial = {1'b0, rt, 2'b01};
    diff  = rem2 - trial;
    if (rem2 >= trial) begin
      return {diff[RemW-1:0], rt[RootW-2:0], 1'b1, w[RadicandW-3:0], 2'b00};
    end
    return {rem2[RemW-1:0], rt[RootW-2:0], 1'b0, w[RadicandW-3:0], 2'b00};
  endfunction

  logic [WordW-1:0] word_r [Stages];
  side_t            side_r [Stages];
  logic             v_r    [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [WordW-1:0] word_in;
    side_t            side_in;
    logic             v_in;
    if (s == 0) begin : g_first
      assign word_in = {{(RemW + RootW){1'b0}}, radicand};
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign word_in = word_r[s-1];
      assign side_in = side_r[s-1];
      assign v_in    = v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        word_r[s] <= sqrt_step(sqrt_step(word_in));
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[Stages-1];
  assign root      = word_r[Stages-1][RadicandW +: RootW];
  assign out_side  = side_r[Stages-1];
endmodule

// File: src/edcl_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, two quotient bits per register stage.
// ----------------------------------------------------------------------------
module edcl_div #(
  parameter int unsigned DividendW = 48,
  parameter int unsigned DivisorW  = 31,
  parameter type side_t = logic
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [DividendW-1:0] dividend,
  input  logic [DivisorW-1:0]  divisor,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [DividendW-1:0] quotient,
  output side_t                out_side
);
  localparam int unsigned PadW   = DividendW + (DividendW % 2);
  localparam int unsigned Stages = PadW / 2;
  localparam int unsigned WordW  = DivisorW + PadW;

  // Word layout: partial remainder above the dividend bits, which are
  // shifted out from the top while quotient bits enter at the bottom.
  function automatic logic [WordW-1:0] div_step(input logic [WordW-1:0] wd,
                                                input logic [DivisorW-1:0] d);
    logic [DivisorW:0]  trial;
    logic [DivisorW:0]  diff;
    logic [PadW-1:0]    w;
    w     = wd[PadW-1:0];
    trial = {wd[WordW-1 -: DivisorW], w[PadW-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      return {diff[DivisorW-1:0], w[PadW-2:0], 1'b1};
    end
    return {trial[DivisorW-1:0], w[PadW-2:0], 1'b0};
  endfunction

  logic [WordW-1:0] word_r [Stages];
  side_t            side_r [Stages];
  logic             v_r    [Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [WordW-1:0] word_in;
    side_t            side_in;
    logic             v_in;
    if (s == 0) begin : g_first
      assign word_in = {{DivisorW{1'b0}}, PadW'(dividend)};
      assign side_in = in_side;
      assign v_in    = in_valid;
    end else begin : g_next
      assign word_in = word_r[s-1];
      assign side_in = side_r[s-1];
      assign v_in    = v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        word_r[s] <= div_step(div_step(word_in, divisor), divisor);
        side_r[s] <= side_in;
      end
    end
  end

  assign out_valid = v_r[Stages-1];
  assign quotient  = word_r[Stages-1][DividendW-1:0];
  assign out_side  = side_r[Stages-1];
endmodule

// File: src/exponential_damage_cohesive_law_core.sv
// ----------------------------------------------------------------------------
// Exponential cohesive-zone damage core
// Turns an interface jump vector and the previous damage into the new damage
// and the saturated traction vector, one interface point per clock unless the output stalls.
// ----------------------------------------------------------------------------
//
//  Channel    | Dir | Payload                                   | Transfer when
//  -----------+-----+-------------------------------------------+--------------------
//  cfg_chan   | in  | register index, 31-bit write data         | valid & ready
//  in_chan    | in  | three jump components, old damage         | valid & ready
//  out_chan   | out | three tractions, damage level, saturation | valid & ready
//
//  A new point can be taken in every cycle while the pipeline is not held.
//  The depth of the pipeline is set by the long pipelined units: the
//  64-bit square root (16 stages), three dividers by the softening length
//  (24, 24 and 32 stages) and the thirteen-term exponential series
//  (three stages per term). Reset is synchronous and active low; it empties
//  the pipeline and loads the register defaults. The whole pipeline moves on
//  one enable; a skid register behind the output register lets one more
//  result finish while the output waits, so in_chan.ready only drops once
//  both are full. The configuration port is always ready.
//
module exponential_damage_cohesive_law_core (
  input  logic          clk,
  input  logic          rst_n,
  edcl_stream_if.sink   cfg_chan,
  edcl_stream_if.sink   in_chan,
  edcl_stream_if.source out_chan
);

  // Geometry that travels with an item up to the damage evaluation.
  // Lane 0 is the normal component, lanes 1 and 2 the tangential ones.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [16:0]      old;
  } geo_t;

  // What the traction stages need once the damage is known.
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
    logic [16:0]      dmg;
  } trac_ctx_t;

  // Running state of the exponential series.
  typedef struct packed {
    logic signed [34:0] sum;
    logic [32:0]        term;
    logic [31:0]        t;
    logic [5:0]         n;
    logic               zero;
    geo_t               geo;
  } exp_ctx_t;

  localparam int unsigned NTerms = edcl_pkg::TaylorTerms;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [30:0] fe_r;
  logic [30:0] tw_r;
  logic [30:0] sl_r;
  logic        irr_r;
  logic [30:0] d0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_r  <= 31'd65536;
      tw_r  <= 31'd65536;
      sl_r  <= 31'd65536;
      irr_r <= 1'b0;
    end else if (cfg_chan.valid) begin
      unique case (cfg_chan.data.index)
        edcl_pkg::REG_FRACTURE_ENERGY:   fe_r  <= cfg_chan.data.wdata;
        edcl_pkg::REG_TANGENTIAL_WEIGHT: tw_r  <= cfg_chan.data.wdata;
        edcl_pkg::REG_SOFTENING_LENGTH:  sl_r  <= cfg_chan.data.wdata;
        edcl_pkg::REG_IRREVERSIBLE_MODE: irr_r <= cfg_chan.data.wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  // A zero softening length behaves as the smallest positive one.
  assign d0 = (sl_r == 31'd0) ? 31'd1 : sl_r;

  // --------------------------------------------------------------------------
  // Pipeline enable and input register
  // --------------------------------------------------------------------------
  logic en;
  logic skid_v_r;

  assign en           = !skid_v_r;
  assign in_chan.ready = en;

  logic               a_v_r;
  edcl_pkg::in_item_t a_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_item_r <= in_chan.data;
    end
  end

  // --------------------------------------------------------------------------
  // Magnitudes and squares of the three jump components.
  // --------------------------------------------------------------------------
  logic [2:0][31:0] a_jump;
  logic [2:0][31:0] a_mag;
  logic             b_v_r;
  geo_t             b_geo_r;
  logic [63:0]      b_sq_r [3];

  assign a_jump[0] = a_item_r.jump_normal;
  assign a_jump[1] = a_item_r.jump_tangent_a;
  assign a_jump[2] = a_item_r.jump_tangent_b;

  for (genvar c = 0; c < 3; c++) begin : g_mag
    assign a_mag[c] = a_jump[c][31] ? (~a_jump[c] + 32'd1) : a_jump[c];
    always_ff @(posedge clk) begin
      if (en) begin
        b_sq_r[c] <= 64'(a_mag[c]) * 64'(a_mag[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_geo_r.mag <= a_mag;
      b_geo_r.neg <= {a_jump[2][31], a_jump[1][31], a_jump[0][31]};
      b_geo_r.old <= a_item_r.old_damage;
    end
  end

  // --------------------------------------------------------------------------
  // Squared effective separation, built over three stages: the tangential
  // sum, its weighting by beta, then the saturating total with dn^2.
  // --------------------------------------------------------------------------
  logic        c_v_r;
  geo_t        c_geo_r;
  logic [63:0] c_t2_r;
  logic [63:0] c_dn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_geo_r <= b_geo_r;
      c_t2_r  <= b_sq_r[1] + b_sq_r[2];
      c_dn2_r <= b_sq_r[0];
    end
  end

  logic        d_v_r;
  geo_t        d_geo_r;
  logic [62:0] d_bh_r;
  logic [62:0] d_bl_r;
  logic [63:0] d_dn2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (en) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_geo_r <= c_geo_r;
      d_bh_r  <= 63'(tw_r) * 63'(c_t2_r[63:32]);
      d_bl_r  <= 63'(tw_r) * 63'(c_t2_r[31:0]);
      d_dn2_r <= c_dn2_r;
    end
  end

  // The weighted tangential part wraps at 64 bits once its high product
  // fits; only an oversized high product or the final carry saturates.
  logic        e_bh_sat;
  logic [63:0] e_sbeta;
  logic [64:0] e_sum;
  logic [63:0] e_s_nxt;
  logic        e_v_r;
  geo_t        e_geo_r;
  logic [63:0] e_s_r;

  always_comb begin
    e_bh_sat = |d_bh_r[62:48];
    e_sbeta  = {d_bh_r[47:0], 16'h0000} + 64'(d_bl_r[62:16]);
    e_sum    = {1'b0, e_sbeta} + {1'b0, d_dn2_r};
    e_s_nxt  = (e_bh_sat || e_sum[64]) ? '1 : e_sum[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (en) begin
      e_v_r <= d_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_geo_r <= d_geo_r;
      e_s_r   <= e_s_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Effective separation and normalized opening x = deff / delta0.
  // --------------------------------------------------------------------------
  logic        sq_v;
  logic [31:0] sq_root;
  geo_t        sq_geo;

  edcl_sqrt #(
    .RadicandW (64),
    .side_t    (geo_t)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (e_v_r),
    .radicand  (e_s_r),
    .in_side   (e_geo_r),
    .out_valid (sq_v),
    .root      (sq_root),
    .out_side  (sq_geo)
  );

  logic        x_v;
  logic [47:0] x_q;
  geo_t        x_geo;

  edcl_div #(
    .DividendW (48),
    .DivisorW  (31),
    .side_t    (geo_t)
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .dividend  ({sq_root, 16'h0000}),
    .divisor   (d0),
    .in_side   (sq_geo),
    .out_valid (x_v),
    .quotient  (x_q),
    .out_side  (x_geo)
  );

  // --------------------------------------------------------------------------
  // exp(-x) = 2^-n * e^-t: convert to base two, then reduce the fraction.
  // --------------------------------------------------------------------------
  logic [53:0] x1_prod;
  logic        x1_v_r;
  logic        x1_zero_r;
  logic [37:0] x1_y_r;
  geo_t        x1_geo_r;

  assign x1_prod = 54'(x_q[20:0]) * 54'(edcl_pkg::Log2eQ32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r <= 1'b0;
    end else if (en) begin
      x1_v_r <= x_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_zero_r <= (|x_q[47:21]) || (x_q[20:0] >= edcl_pkg::ExpCutoff);
      x1_y_r    <= x1_prod[53:16];
      x1_geo_r  <= x_geo;
    end
  end

  logic [63:0] x2_prod;
  exp_ctx_t    tc_ctx_r [NTerms+1];
  logic        tc_v_r   [NTerms+1];

  assign x2_prod = 64'(x1_y_r[31:0]) * 64'(edcl_pkg::Ln2Q32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tc_v_r[0] <= 1'b0;
    end else if (en) begin
      tc_v_r[0] <= x1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tc_ctx_r[0].sum  <= 35'sh1_0000_0000;
      tc_ctx_r[0].term <= 33'h1_0000_0000;
      tc_ctx_r[0].t    <= x2_prod[63:32];
      tc_ctx_r[0].n    <= x1_y_r[37:32];
      tc_ctx_r[0].zero <= x1_zero_r;
      tc_ctx_r[0].geo  <= x1_geo_r;
    end
  end

  // Taylor series of e^-t, one term per three stages: the product with t,
  // the reciprocal multiply for the division by k, and the exact correction
  // of that quotient together with the signed accumulation.
  exp_ctx_t    tp_ctx_r [NTerms];
  logic [31:0] tp_q_r   [NTerms];
  logic        tp_v_r   [NTerms];
  exp_ctx_t    tr_ctx_r [NTerms];
  logic [31:0] tr_q_r   [NTerms];
  logic [31:0] tr_qm_r  [NTerms];
  logic        tr_v_r   [NTerms];

  for (genvar i = 0; i < NTerms; i++) begin : g_term
    localparam logic [3:0]  K        = 4'(i + 1);
    localparam logic [33:0] RecipK   = edcl_pkg::taylor_recip(i + 1);
    localparam bit          Subtract = ((i % 2) == 0);

    logic [64:0] prod;
    logic [65:0] qm_prod;
    logic [35:0] back;
    logic [31:0] rem;
    logic [31:0] qf;
    exp_ctx_t    upd;

    assign prod    = 65'(tc_ctx_r[i].term) * 65'(tc_ctx_r[i].t);
    assign qm_prod = 66'(tp_q_r[i]) * 66'(RecipK);
    assign back    = 36'(tr_qm_r[i]) * 36'(K);
    assign rem     = tr_q_r[i] - back[31:0];
    assign qf      = (rem >= 32'(K)) ? (tr_qm_r[i] + 32'd1) : tr_qm_r[i];

    always_comb begin
      upd      = tr_ctx_r[i];
      upd.term = {1'b0, qf};
      if (Subtract) begin
        upd.sum = tr_ctx_r[i].sum - $signed({3'b000, qf});
      end else begin
        upd.sum = tr_ctx_r[i].sum + $signed({3'b000, qf});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tp_v_r[i]   <= 1'b0;
        tr_v_r[i]   <= 1'b0;
        tc_v_r[i+1] <= 1'b0;
      end else if (en) begin
        tp_v_r[i]   <= tc_v_r[i];
        tr_v_r[i]   <= tp_v_r[i];
        tc_v_r[i+1] <= tr_v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tp_q_r[i]     <= prod[63:32];
        tp_ctx_r[i]   <= tc_ctx_r[i];
        tr_qm_r[i]    <= qm_prod[64:33];
        tr_q_r[i]     <= tp_q_r[i];
        tr_ctx_r[i]   <= tp_ctx_r[i];
        tc_ctx_r[i+1] <= upd;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Scale by 2^-n, round to Q0.16 and form the damage.
  // --------------------------------------------------------------------------
  exp_ctx_t    f1_ctx;
  logic [33:0] f1_sumc;
  logic        f1_v_r;
  logic        f1_zero_r;
  logic [33:0] f1_ex_r;
  geo_t        f1_geo_r;

  assign f1_ctx  = tc_ctx_r[NTerms];
  assign f1_sumc = f1_ctx.sum[34] ? 34'd0 : f1_ctx.sum[33:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (en) begin
      f1_v_r <= tc_v_r[NTerms];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_ex_r   <= f1_sumc >> f1_ctx.n;
      f1_zero_r <= f1_ctx.zero;
      f1_geo_r  <= f1_ctx.geo;
    end
  end

  logic [34:0] f2_rnd;
  logic [16:0] f2_exp;
  logic [16:0] f2_oldc;
  logic [16:0] f2_dmg;
  logic        f2_v_r;
  trac_ctx_t   f2_ctx_r;

  always_comb begin
    f2_rnd = 35'(f1_ex_r) + 35'd32768;
    if (f1_zero_r) begin
      f2_exp = 17'd0;
    end else if (f2_rnd[34:16] > 19'(edcl_pkg::OneQ16)) begin
      f2_exp = edcl_pkg::OneQ16;
    end else begin
      f2_exp = f2_rnd[32:16];
    end
    f2_oldc = (f1_geo_r.old > edcl_pkg::OneQ16) ? edcl_pkg::OneQ16 : f1_geo_r.old;
    f2_dmg  = edcl_pkg::OneQ16 - f2_exp;
    if (irr_r && (f2_oldc > f2_dmg)) begin
      f2_dmg = f2_oldc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (en) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2_ctx_r.mag <= f1_geo_r.mag;
      f2_ctx_r.neg <= f1_geo_r.neg;
      f2_ctx_r.dmg <= f2_dmg;
    end
  end

  // --------------------------------------------------------------------------
  // Stiffness P = Gc * (1 - d) / delta0^2, as two successive divisions.
  // --------------------------------------------------------------------------
  logic [47:0] g_prod;
  logic        g_v_r;
  logic [30:0] g_g1_r;
  trac_ctx_t   g_ctx_r;

  assign g_prod = 48'(fe_r) * 48'(edcl_pkg::OneQ16 - f2_ctx_r.dmg);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_g1_r  <= g_prod[46:16];
      g_ctx_r <= f2_ctx_r;
    end
  end

  logic        h_v;
  logic [46:0] h_q;
  trac_ctx_t   h_ctx;

  edcl_div #(
    .DividendW (47),
    .DivisorW  (31),
    .side_t    (trac_ctx_t)
  ) u_div_h (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_v_r),
    .dividend  ({g_g1_r, 16'h0000}),
    .divisor   (d0),
    .in_side   (g_ctx_r),
    .out_valid (h_v),
    .quotient  (h_q),
    .out_side  (h_ctx)
  );

  logic        p_v;
  logic [62:0] p_q;
  trac_ctx_t   p_ctx;

  edcl_div #(
    .DividendW (63),
    .DivisorW  (31),
    .side_t    (trac_ctx_t)
  ) u_div_p (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (h_v),
    .dividend  ({h_q, 16'h0000}),
    .divisor   (d0),
    .in_side   (h_ctx),
    .out_valid (p_v),
    .quotient  (p_q),
    .out_side  (p_ctx)
  );

  // --------------------------------------------------------------------------
  // Tractions: |T| = P * |j|, split into high and low halves of P, then
  // clipped to the 32-bit range with the sign opposite to the jump.
  // --------------------------------------------------------------------------
  logic        m1_v_r;
  trac_ctx_t   m1_ctx_r;
  logic [62:0] m1_hp_r [3];
  logic [63:0] m1_lp_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= p_v;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_mul
    always_ff @(posedge clk) begin
      if (en) begin
        m1_hp_r[c] <= 63'(p_q[62:32]) * 63'(p_ctx.mag[c]);
        m1_lp_r[c] <= 64'(p_q[31:0]) * 64'(p_ctx.mag[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctx_r <= p_ctx;
    end
  end

  logic [2:0][31:0] m2_trac;
  logic [2:0]       m2_clip;

  for (genvar c = 0; c < 3; c++) begin : g_clip
    logic        ovf;
    logic [48:0] mag;
    logic [31:0] limit;
    logic [31:0] magf;
    always_comb begin
      ovf        = |m1_hp_r[c][62:32];
      mag        = {1'b0, m1_hp_r[c][31:0], 16'h0000} + 49'(m1_lp_r[c][63:16]);
      limit      = m1_ctx_r.neg[c] ? 32'h7FFF_FFFF : 32'h8000_0000;
      m2_clip[c] = ovf || (mag > 49'(limit));
      magf       = m2_clip[c] ? limit : mag[31:0];
      m2_trac[c] = m1_ctx_r.neg[c] ? magf : (~magf + 32'd1);
    end
  end

  logic                m2_v_r;
  edcl_pkg::out_item_t m2_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (en) begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_item_r.traction_normal    <= m2_trac[0];
      m2_item_r.traction_tangent_a <= m2_trac[1];
      m2_item_r.traction_tangent_b <= m2_trac[2];
      m2_item_r.damage_level       <= m1_ctx_r.dmg;
      m2_item_r.saturated          <= |m2_clip;
    end
  end

  // --------------------------------------------------------------------------
  // Output register with a skid register behind it. The skid only fills
  // when the output holds an untaken result and the pipeline delivers one
  // more; while it is full the whole pipeline holds.
  // --------------------------------------------------------------------------
  logic                out_v_r;
  edcl_pkg::out_item_t out_item_r;
  edcl_pkg::out_item_t skid_item_r;
  logic                out_load;

  assign out_load = !out_v_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r  <= skid_v_r || m2_v_r;
      skid_v_r <= 1'b0;
    end else if (m2_v_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= skid_v_r ? skid_item_r : m2_item_r;
    end else if (m2_v_r && en) begin
      skid_item_r <= m2_item_r;
    end
  end

  assign out_chan.valid = out_v_r;
  assign out_chan.data  = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The skid register is only ever used behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output is empty");

  // Damage never exceeds one.
  a_damage_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_item_r.damage_level <= edcl_pkg::OneQ16))
    else $error("damage level above one");

  // A fully damaged interface carries no traction.
  a_full_damage_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_item_r.damage_level == edcl_pkg::OneQ16)) |->
      ((out_item_r.traction_normal == 32'sd0) &&
       (out_item_r.traction_tangent_a == 32'sd0) &&
       (out_item_r.traction_tangent_b == 32'sd0) && !out_item_r.saturated))
    else $error("nonzero traction at full damage");

  // A clipped result has at least one traction at a limit of the range.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_item_r.saturated) |->
      ((out_item_r.traction_normal == 32'sh7FFF_FFFF) ||
       (out_item_r.traction_normal == 32'sh8000_0000) ||
       (out_item_r.traction_tangent_a == 32'sh7FFF_FFFF) ||
       (out_item_r.traction_tangent_a == 32'sh8000_0000) ||
       (out_item_r.traction_tangent_b == 32'sh7FFF_FFFF) ||
       (out_item_r.traction_tangent_b == 32'sh8000_0000)))
    else $error("saturation flag without a clipped traction");

endmodule

// File: tb/exponential_damage_cohesive_law_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Exponential cohesive damage core regression
// Drives interface jump vectors through the core under several register
// settings and random handshake pressure, predicts every traction and damage
// result in the bench and compares them field by field in arrival order.
// ----------------------------------------------------------------------------
module exponential_damage_cohesive_law_core_tb;

  localparam int unsigned LatencyCycles = 160;
  localparam int unsigned HoldCycles    = 400;
  localparam longint      CycleLimit    = 600000;
  localparam int unsigned DamageW       = edcl_pkg::DamageW;
  localparam int unsigned CfgW          = edcl_pkg::CfgW;

  logic clk;
  logic rst_n;

  edcl_stream_if #(.payload_t(edcl_pkg::cfg_write_t)) cfg_chan ();
  edcl_stream_if #(.payload_t(edcl_pkg::in_item_t))   in_chan ();
  edcl_stream_if #(.payload_t(edcl_pkg::out_item_t))  out_chan ();

  exponential_damage_cohesive_law_core u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_chan(cfg_chan),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // Bench copy of the register file.
  logic [63:0] gc_reg;
  logic [63:0] beta_reg;
  logic [63:0] delta0_reg;
  logic        irrev_reg;

  edcl_pkg::out_item_t pending_results[$];
  int        error_count;
  int        points_sent;
  int        results_checked;
  int        saturated_seen;
  int        config_writes;
  longint    cycle_count;

  // When set, neither side idles between transfers.
  logic   back_to_back;
  logic   hold_request;
  int     hold_left;
  int     stall_left;

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor of the damage law, all in 64-bit integer arithmetic.
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // exp(-x) with x in Q16.16, returned in Q0.16.
  function automatic logic [63:0] decay_q16(input logic [63:0] x);
    logic [63:0] y, n, g, t, term, ex, r;
    longint      sum;
    if (x >= 64'(edcl_pkg::ExpCutoff)) return 0;
    y = (x * 64'(edcl_pkg::Log2eQ32)) >> 16;
    n = y >> 32;
    g = y & 64'hFFFF_FFFF;
    t = (g * 64'(edcl_pkg::Ln2Q32)) >> 32;
    sum  = longint'(1) << 32;
    term = 64'h1 << 32;
    for (int k = 1; k <= 13; k++) begin
      term = ((term * t) >> 32) / 64'(k);
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    ex = (n < 64) ? (64'(sum) >> n) : 0;
    r = (ex + 64'd32768) >> 16;
    return (r > 64'd65536) ? 64'd65536 : r;
  endfunction

  // Traction -p*j in Q16.16, clipped to the 32-bit range.
  function automatic logic [31:0] clipped_traction(input logic [63:0] p,
                                                   input logic [63:0] absj,
                                                   input logic neg,
                                                   output logic clipped);
    logic [63:0] limit, mag, hp;
    limit = neg ? 64'h7FFF_FFFF : 64'h8000_0000;
    hp = (p >> 32) * absj;
    if (hp >= (64'h1 << 32)) mag = limit + 1;
    else mag = (hp << 16) + (((p & 64'hFFFF_FFFF) * absj) >> 16);
    clipped = (mag > limit);
    if (clipped) mag = limit;
    return neg ? mag[31:0] : (32'd0 - mag[31:0]);
  endfunction

  function automatic edcl_pkg::out_item_t predict_point(input edcl_pkg::in_item_t pt);
    edcl_pkg::out_item_t res;
    logic [63:0] mag[3];
    logic        neg[3];
    logic [63:0] d0, t2, bh, s, dn2, deff, x, dmg, old, g1, h, p;
    logic        clip;
    logic [31:0] tr[3];
    logic [31:0] comp[3];
    comp[0] = pt.jump_normal;
    comp[1] = pt.jump_tangent_a;
    comp[2] = pt.jump_tangent_b;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][31];
      mag[i] = neg[i] ? (64'h1_0000_0000 - 64'(comp[i])) : 64'(comp[i]);
    end
    d0 = (delta0_reg == 0) ? 64'd1 : delta0_reg;
    t2 = mag[1] * mag[1] + mag[2] * mag[2];
    bh = beta_reg * (t2 >> 32);
    if (bh >= (64'h1 << 48)) s = '1;
    else s = (bh << 16) + ((beta_reg * (t2 & 64'hFFFF_FFFF)) >> 16);
    dn2 = mag[0] * mag[0];
    if (s > ~dn2) s = '1;
    else s = s + dn2;
    deff = floor_sqrt(s);
    x = (deff << 16) / d0;
    dmg = 64'd65536 - decay_q16(x);
    old = 64'(pt.old_damage);
    if (old > 64'd65536) old = 64'd65536;
    if (irrev_reg && old > dmg) dmg = old;
    g1 = (gc_reg * (64'd65536 - dmg)) >> 16;
    h = (g1 << 16) / d0;
    p = (h << 16) / d0;
    res.saturated = 1'b0;
    for (int i = 0; i < 3; i++) begin
      tr[i] = clipped_traction(p, mag[i], neg[i], clip);
      res.saturated = res.saturated | clip;
    end
    res.traction_normal    = tr[0];
    res.traction_tangent_a = tr[1];
    res.traction_tangent_b = tr[2];
    res.damage_level       = dmg[DamageW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: every transfer on the output is compared with the oldest
  // prediction that is still waiting.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    edcl_pkg::out_item_t exp_r;
    edcl_pkg::out_item_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = out_chan.data;
      if (pending_results.size() == 0) begin
        $error("result arrived with no prediction waiting");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (got.saturated) saturated_seen++;
        if (got.traction_normal !== exp_r.traction_normal) begin
          $error("traction_normal: expected %0d, actual %0d",
                 exp_r.traction_normal, got.traction_normal);
          error_count++;
        end
        if (got.traction_tangent_a !== exp_r.traction_tangent_a) begin
          $error("traction_tangent_a: expected %0d, actual %0d",
                 exp_r.traction_tangent_a, got.traction_tangent_a);
          error_count++;
        end
        if (got.traction_tangent_b !== exp_r.traction_tangent_b) begin
          $error("traction_tangent_b: expected %0d, actual %0d",
                 exp_r.traction_tangent_b, got.traction_tangent_b);
          error_count++;
        end
        if (got.damage_level !== exp_r.damage_level) begin
          $error("damage_level: expected %0d, actual %0d",
                 exp_r.damage_level, got.damage_level);
          error_count++;
        end
        if (got.saturated !== exp_r.saturated) begin
          $error("saturated: expected %0d, actual %0d",
                 exp_r.saturated, got.saturated);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver. After each transfer it draws a random stall, which may be none.
  // A hold request makes it refuse results for a long stretch, which it
  // counts itself, so that the pipeline and its skid register fill up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      hold_left      <= 0;
      stall_left     <= 0;
    end else if (hold_request) begin
      hold_left      <= HoldCycles;
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left      <= hold_left - 1;
      out_chan.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left     <= stall_left - 1;
      out_chan.ready <= 1'b0;
    end else if (out_chan.valid && out_chan.ready) begin
      draw = back_to_back ? 0 : $urandom_range(0, 18);
      stall_left     <= draw;
      out_chan.ready <= (draw == 0);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("cycle limit reached with %0d results outstanding",
               pending_results.size());
      $display("exponential_damage_cohesive_law_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared stimulus tasks.
  // ---------------------------------------------------------------------------

  // Offers one point after a random gap; valid stays high if the next point
  // follows at once, so it is never lowered and raised in the same step.
  task automatic send_point(input edcl_pkg::in_item_t pt);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data  <= pt;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(predict_point(pt));
    points_sent++;
  endtask

  task automatic stop_sending();
    in_chan.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every predicted result has arrived, then lets the pipeline
  // drain for its full depth before anything else happens.
  task automatic drain_results();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);
  endtask

  // One register write; valid is lowered for a cycle afterwards so that
  // back-to-back writes never drive it twice in one step.
  task automatic write_reg(input edcl_pkg::reg_index_t idx, input logic [CfgW-1:0] value);
    edcl_pkg::cfg_write_t w;
    w.index = idx;
    w.wdata = value;
    cfg_chan.valid <= 1'b1;
    cfg_chan.data  <= w;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cfg_chan.valid <= 1'b0;
    @(posedge clk);
    config_writes++;
    case (idx)
      edcl_pkg::REG_FRACTURE_ENERGY:   gc_reg     = 64'(value);
      edcl_pkg::REG_TANGENTIAL_WEIGHT: beta_reg   = 64'(value);
      edcl_pkg::REG_SOFTENING_LENGTH:  delta0_reg = 64'(value);
      edcl_pkg::REG_IRREVERSIBLE_MODE: irrev_reg  = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [CfgW-1:0] gc, input logic [CfgW-1:0] beta,
                           input logic [CfgW-1:0] d0, input logic irrev);
    write_reg(edcl_pkg::REG_FRACTURE_ENERGY, gc);
    write_reg(edcl_pkg::REG_TANGENTIAL_WEIGHT, beta);
    write_reg(edcl_pkg::REG_SOFTENING_LENGTH, d0);
    write_reg(edcl_pkg::REG_IRREVERSIBLE_MODE, {30'd0, irrev});
  endtask

  // Jump components: mostly on the scale of the softening length so that the
  // damage sweeps its whole range, the rest very small values or full-range noise.
  function automatic logic [31:0] rand_jump();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 4))
      0:       return raw;
      1:       return 32'($signed(raw) >>> $urandom_range(20, 31));
      default: return 32'($signed(raw) >>> $urandom_range(8, 19));
    endcase
  endfunction

  function automatic logic [DamageW-1:0] rand_old_damage();
    case ($urandom_range(0, 9))
      0:       return DamageW'($urandom);
      1:       return edcl_pkg::OneQ16;
      2:       return '0;
      default: return DamageW'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic edcl_pkg::in_item_t make_point(input logic [31:0] n,
                                                    input logic [31:0] a,
                                                    input logic [31:0] b,
                                                    input logic [DamageW-1:0] old);
    edcl_pkg::in_item_t pt;
    pt.jump_normal    = n;
    pt.jump_tangent_a = a;
    pt.jump_tangent_b = b;
    pt.old_damage     = old;
    return pt;
  endfunction

  task automatic send_random_points(input int count);
    repeat (count) send_point(make_point(rand_jump(), rand_jump(), rand_jump(),
                                         rand_old_damage()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes at the reset defaults and with irreversibility on.
  task automatic test_directed_extremes();
    send_point(make_point(32'd0, 32'd0, 32'd0, '0));
    send_point(make_point(32'h0001_0000, 32'd0, 32'd0, '0));
    send_point(make_point(32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000, 17'd30000));
    send_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0));
    send_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          edcl_pkg::OneQ16));
    send_point(make_point(32'd1, 32'hFFFF_FFFF, 32'd1, 17'h1FFFF));
    drain_results();
    write_reg(edcl_pkg::REG_IRREVERSIBLE_MODE, 31'd1);
    // Old damage above one is clamped; full old damage zeroes the traction.
    send_point(make_point(32'h0000_4000, 32'd0, 32'd0, 17'h1FFFF));
    send_point(make_point(32'h0000_4000, 32'd0, 32'd0, edcl_pkg::OneQ16));
    send_point(make_point(32'h0000_4000, 32'h0000_1000, 32'd0, 17'd40000));
    send_point(make_point(32'h0000_0100, 32'd0, 32'd0, 17'd65535));
    drain_results();
  endtask

  // Zero softening length is taken as the smallest step, and a huge opening
  // saturates the squared separation; large energies force clipping.
  task automatic test_register_extremes();
    write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 1'b0);
    send_point(make_point(32'd0, 32'd0, 32'd0, '0));
    send_point(make_point(32'd1, 32'd0, 32'd0, '0));
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0));
    drain_results();
    write_all(31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF, 1'b0);
    send_point(make_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, '0));
    send_point(make_point(32'h4000_0000, 32'h1234_5678, 32'd0, 17'd100));
    send_point(make_point(32'h8000_0000, 32'd0, 32'h8000_0000, '0));
    drain_results();
    write_all(31'h7FFF_FFFF, 31'h0000_0001, 31'd1, 1'b1);
    send_point(make_point(32'd0, 32'd3, 32'hFFFF_FFFD, '0));
    send_point(make_point(32'd0, 32'd0, 32'd0, 17'd1));
    drain_results();
    write_all(31'd0, 31'h0001_0000, 31'h0001_0000, 1'b0);
    send_point(make_point(32'h0000_8000, 32'hFFFF_8000, 32'd0, '0));
    drain_results();
  endtask

  // Random points under a series of register settings.
  task automatic test_config_sweep();
    write_all(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 1'b0);
    send_random_points(150);
    drain_results();
    write_all(31'h0064_0000, 31'h0000_4000, 31'h0000_0800, 1'b1);
    send_random_points(150);
    drain_results();
    write_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, 1'b0);
    send_random_points(60);
    drain_results();
    write_all(31'd0, 31'd0, 31'h7FFF_FFFF, 1'b1);
    send_random_points(60);
    drain_results();
    for (int i = 0; i < 4; i++) begin
      write_all(31'($urandom), 31'($urandom >> $urandom_range(0, 31)),
                31'($urandom >> $urandom_range(8, 24)), 1'($urandom));
      send_random_points(80);
      drain_results();
    end
  endtask

  // The receiver holds off while points keep coming at full rate, so the core
  // must stall its input; all results are drained, then a second run follows.
  task automatic test_backpressure();
    write_all(31'h0010_0000, 31'h0002_0000, 31'h0000_4000, 1'b1);
    back_to_back = 1'b1;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    send_random_points(300);
    drain_results();
    send_random_points(100);
    back_to_back = 1'b0;
    drain_results();
  endtask

  // Long mixed run with random idling on both sides.
  task automatic test_random_soak();
    write_all(31'($urandom_range(1, 32'h00FF_FFFF)), 31'($urandom_range(0, 32'h0004_0000)),
              31'($urandom_range(1, 32'h0004_0000)), 1'($urandom));
    send_random_points(200);
    drain_results();
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    back_to_back   = 1'b0;
    hold_request   = 1'b0;
    error_count    = 0;
    points_sent    = 0;
    results_checked = 0;
    saturated_seen = 0;
    config_writes  = 0;
    cycle_count    = 0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data  = '0;
    in_chan.valid  = 1'b0;
    in_chan.data   = '0;
    gc_reg         = 64'd65536;
    beta_reg       = 64'd65536;
    delta0_reg     = 64'd65536;
    irrev_reg      = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_register_extremes();
    test_config_sweep();
    test_backpressure();
    test_random_soak();

    drain_results();
    $display("Covered %0d points, %0d results checked (%0d clipped), %0d register writes.",
             points_sent, results_checked, saturated_seen, config_writes);
    $display("Register extremes, irreversibility, old damage clamping and full stalls ran.");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("exponential_damage_cohesive_law_core regression: pass");
    end else begin
      $display("exponential_damage_cohesive_law_core regression: fail");
    end
    $finish;
  end

endmodule
